[rtl/wpu_pkg.sv]
// wpu_pkg: shared types and codes of the wav pcm stream unpacker
// holds the byte and result records and the status and kind codes
// no dependencies
package wpu_pkg;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_MISSING      = 3'd1,
      ST_NOT_PCM      = 3'd2,
      ST_CHANNELS     = 3'd3,
      ST_INCONSISTENT = 3'd4,
      ST_DEPTH        = 3'd5,
      ST_DATA_FIRST   = 3'd6
   } wpu_status_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_STATUS = 1'b1
   } wpu_kind_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } wpu_byte_type;

   typedef struct packed {
      wpu_kind_type   kind;
      logic           channel;
      logic [31:0]    sample_value;
      logic           frame_end;
      wpu_status_type status;
      logic [31:0]    sample_rate;
      logic [15:0]    bits_per_sample;
      logic [15:0]    channel_count;
      logic           last;
   } wpu_result_type;

   // results of one byte: a sample, a status report, or both at end of file
   typedef struct packed {
      logic           sample_valid;
      logic           status_valid;
      wpu_result_type sample;
      wpu_result_type status;
   } wpu_push_type;

endpackage

[rtl/wpu_in_reg.sv]
// wpu_in_reg: input register stage for the file byte stream
// depends on wpu_pkg for the byte record
module wpu_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  wpu_pkg::wpu_byte_type in_item,
   output logic                  out_valid,
   input  logic                  out_take,
   output wpu_pkg::wpu_byte_type out_item
);
   import wpu_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   wpu_byte_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

[rtl/wpu_parser.sv]
// wpu_parser: riff/wave header scan, format capture and sample unpacking
// one byte per cycle while in_go is high; format check is applied in the cycle after its last byte
// depends on wpu_pkg
module wpu_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_go,
   input  wpu_pkg::wpu_byte_type in_item,
   output wpu_pkg::wpu_push_type push
);
   import wpu_pkg::*;

   localparam logic [31:0] RIFF_LE  = 32'h4646_4952;
   localparam logic [31:0] WAVE_LE  = 32'h4556_4157;
   localparam logic [23:0] TAG_FMT  = 24'h66_6D74;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   logic [31:0]    pos_ff, pos_in;
   logic [31:0]    recent_ff, recent_in;
   logic           fmt_found_ff, fmt_found_in;
   logic [31:0]    fmt_off_ff, fmt_off_in;
   logic           data_found_ff, data_found_in;
   logic [31:0]    data_off_ff, data_off_in;
   logic           header_ok_ff, header_ok_in;
   logic [15:0]    fmt_word_ff, fmt_word_in;
   logic [15:0]    chan_word_ff, chan_word_in;
   logic [31:0]    rate_word_ff, rate_word_in;
   logic [31:0]    byte_rate_ff, byte_rate_in;
   logic [15:0]    align_ff, align_in;
   logic [15:0]    depth_ff, depth_in;
   logic [31:0]    remain_ff, remain_in;
   logic [23:0]    assembly_ff, assembly_in;
   logic [1:0]     bis_ff, bis_in;
   logic           cur_chan_ff, cur_chan_in;
   wpu_status_type err_ff, err_in;
   logic           vpend_ff, vpend_in;

   // format check on the captured words
   wpu_status_type vcode;
   wpu_status_type err_eff;
   logic           ch_ok;
   logic [31:0]    ch_rate;
   logic [31:0]    rate_prod;
   logic [16:0]    depth_adj;
   logic [16:0]    depth_q;
   logic [16:0]    align_exp;
   logic           depth_ok;

   always_comb begin
      ch_ok     = (chan_word_ff == 16'd1) || (chan_word_ff == 16'd2);
      ch_rate   = (chan_word_ff == 16'd2) ? {rate_word_ff[30:0], 1'b0} : rate_word_ff;
      rate_prod = ch_rate * {{16{depth_ff[15]}}, depth_ff};
      // signed divide by 8 truncating towards zero
      depth_adj = {depth_ff[15], depth_ff} + (depth_ff[15] ? 17'd7 : 17'd0);
      depth_q   = {{3{depth_adj[16]}}, depth_adj[16:3]};
      align_exp = (chan_word_ff == 16'd2) ? {depth_q[15:0], 1'b0} : depth_q;
      depth_ok  = (depth_ff == 16'd8) || (depth_ff == 16'd16) ||
                  (depth_ff == 16'd24) || (depth_ff == 16'd32);
      if (fmt_word_ff != 16'd1) begin
         vcode = ST_NOT_PCM;
      end else if (!ch_ok) begin
         vcode = ST_CHANNELS;
      end else if ((byte_rate_ff != {3'b000, rate_prod[31:3]}) ||
                   ({align_ff[15], align_ff} != align_exp)) begin
         vcode = ST_INCONSISTENT;
      end else if (!depth_ok) begin
         vcode = ST_DEPTH;
      end else begin
         vcode = ST_OK;
      end
      err_eff = (vpend_ff && (err_ff == ST_OK)) ? vcode : err_ff;
   end

   logic [31:0] p;
   logic [7:0]  b;
   logic [31:0] rel_f;
   logic [31:0] rel_d;
   logic [31:0] size;
   logic [2:0]  bps;
   logic [3:0]  block;
   logic        go;
   logic [31:0] word;
   logic [2:0]  shv;
   logic [31:0] v;
   logic        stereo;
   logic        missing;

   always_comb begin
      pos_in        = pos_ff;
      recent_in     = recent_ff;
      fmt_found_in  = fmt_found_ff;
      fmt_off_in    = fmt_off_ff;
      data_found_in = data_found_ff;
      data_off_in   = data_off_ff;
      header_ok_in  = header_ok_ff;
      fmt_word_in   = fmt_word_ff;
      chan_word_in  = chan_word_ff;
      rate_word_in  = rate_word_ff;
      byte_rate_in  = byte_rate_ff;
      align_in      = align_ff;
      depth_in      = depth_ff;
      remain_in     = remain_ff;
      assembly_in   = assembly_ff;
      bis_in        = bis_ff;
      cur_chan_in   = cur_chan_ff;
      err_in        = err_eff;
      vpend_in      = 1'b0;
      push          = '0;

      p       = pos_ff;
      b       = in_item.file_byte;
      rel_f   = p - fmt_off_ff;
      rel_d   = p - data_off_ff;
      size    = remain_ff | ({24'd0, b} << {rel_d[1:0], 3'b000});
      bps     = depth_ff[5:3];
      block   = (chan_word_ff == 16'd2) ? {bps, 1'b0} : {1'b0, bps};
      go      = (bis_ff == 2'd0 && !cur_chan_ff) ? (remain_ff >= {28'd0, block}) : 1'b1;
      word    = {8'd0, assembly_ff} | ({24'd0, b} << {bis_ff, 3'b000});
      shv     = 3'd4 - bps;
      v       = word << {shv[1:0], 3'b000};
      stereo  = (chan_word_ff == 16'd2);
      missing = 1'b0;

      if (in_go) begin
         // fixed header bytes
         if (p < 32'd4 && b != RIFF_LE[{p[1:0], 3'b000} +: 8]) begin
            header_ok_in = 1'b0;
         end
         if (p >= 32'd8 && p < 32'd12 && b != WAVE_LE[{p[1:0], 3'b000} +: 8]) begin
            header_ok_in = 1'b0;
         end

         recent_in = {recent_ff[23:0], b};

         // format fields, little-endian
         if (fmt_found_ff) begin
            if (rel_f >= 32'd8 && rel_f < 32'd24) begin
               case (rel_f[4:1])
                  4'd4: begin
                     fmt_word_in = fmt_word_ff | ({8'd0, b} << {rel_f[0], 3'b000});
                  end
                  4'd5: begin
                     chan_word_in = chan_word_ff | ({8'd0, b} << {rel_f[0], 3'b000});
                  end
                  4'd6, 4'd7: begin
                     rate_word_in = rate_word_ff | ({24'd0, b} << {rel_f[1:0], 3'b000});
                  end
                  4'd8, 4'd9: begin
                     byte_rate_in = byte_rate_ff | ({24'd0, b} << {rel_f[1:0], 3'b000});
                  end
                  4'd10: begin
                     align_in = align_ff | ({8'd0, b} << {rel_f[0], 3'b000});
                  end
                  4'd11: begin
                     depth_in = depth_ff | ({8'd0, b} << {rel_f[0], 3'b000});
                  end
                  default: begin
                  end
               endcase
               if (rel_f == 32'd23) begin
                  vpend_in = 1'b1;
               end
            end
         end else if (p >= 32'd2 && recent_in[23:0] == TAG_FMT) begin
            fmt_found_in = 1'b1;
            fmt_off_in   = p - 32'd2;
         end

         // data size, then samples for whole frames only
         if (data_found_ff) begin
            if (rel_d >= 32'd4 && rel_d < 32'd8) begin
               if (rel_d == 32'd7) begin
                  remain_in = (err_eff != ST_OK || size[31]) ? 32'd0 : size;
               end else begin
                  remain_in = size;
               end
            end else if (rel_d >= 32'd8 && remain_ff != 32'd0 && go) begin
               remain_in = remain_ff - 32'd1;
               if ({1'b0, bis_ff} + 3'd1 >= bps) begin
                  push.sample_valid           = 1'b1;
                  push.sample.kind            = KIND_SAMPLE;
                  push.sample.channel         = cur_chan_ff;
                  push.sample.sample_value    = (bps == 3'd1) ? {~v[31], v[30:0]} : v;
                  push.sample.frame_end       = stereo ? cur_chan_ff : 1'b1;
                  push.sample.status          = ST_OK;
                  assembly_in                 = 24'd0;
                  bis_in                      = 2'd0;
                  if (stereo) begin
                     cur_chan_in = !cur_chan_ff;
                  end
               end else begin
                  assembly_in = word[23:0];
                  bis_in      = bis_ff + 2'd1;
               end
            end
         end else if (p >= 32'd3 && recent_in == TAG_DATA) begin
            data_found_in = 1'b1;
            data_off_in   = p - 32'd3;
            if (!fmt_found_in ||
                ({1'b0, data_off_in} < {1'b0, fmt_off_in} + 33'd24)) begin
               if (err_in == ST_OK) begin
                  err_in = ST_DATA_FIRST;
               end
            end
         end

         pos_in = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;

         if (in_item.end_of_file) begin
            missing = !header_ok_in || pos_in < 32'd12 || !fmt_found_in ||
                      (pos_in - fmt_off_in) < 32'd24 || !data_found_in ||
                      (pos_in - data_off_in) < 32'd8;
            push.status_valid           = 1'b1;
            push.status.kind            = KIND_STATUS;
            push.status.status          = missing ? ST_MISSING : err_in;
            push.status.sample_rate     = rate_word_in;
            push.status.bits_per_sample = depth_in;
            push.status.channel_count   = chan_word_in;
            push.status.last            = 1'b1;
            // back to the start-of-file state
            pos_in        = '0;
            recent_in     = '0;
            fmt_found_in  = 1'b0;
            fmt_off_in    = '0;
            data_found_in = 1'b0;
            data_off_in   = '0;
            header_ok_in  = 1'b1;
            fmt_word_in   = '0;
            chan_word_in  = '0;
            rate_word_in  = '0;
            byte_rate_in  = '0;
            align_in      = '0;
            depth_in      = '0;
            remain_in     = '0;
            assembly_in   = '0;
            bis_in        = '0;
            cur_chan_in   = 1'b0;
            err_in        = ST_OK;
            vpend_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         recent_ff     <= '0;
         fmt_found_ff  <= 1'b0;
         fmt_off_ff    <= '0;
         data_found_ff <= 1'b0;
         data_off_ff   <= '0;
         header_ok_ff  <= 1'b1;
         fmt_word_ff   <= '0;
         chan_word_ff  <= '0;
         rate_word_ff  <= '0;
         byte_rate_ff  <= '0;
         align_ff      <= '0;
         depth_ff      <= '0;
         remain_ff     <= '0;
         assembly_ff   <= '0;
         bis_ff        <= '0;
         cur_chan_ff   <= 1'b0;
         err_ff        <= ST_OK;
         vpend_ff      <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         recent_ff     <= recent_in;
         fmt_found_ff  <= fmt_found_in;
         fmt_off_ff    <= fmt_off_in;
         data_found_ff <= data_found_in;
         data_off_ff   <= data_off_in;
         header_ok_ff  <= header_ok_in;
         fmt_word_ff   <= fmt_word_in;
         chan_word_ff  <= chan_word_in;
         rate_word_ff  <= rate_word_in;
         byte_rate_ff  <= byte_rate_in;
         align_ff      <= align_in;
         depth_ff      <= depth_in;
         remain_ff     <= remain_in;
         assembly_ff   <= assembly_in;
         bis_ff        <= bis_in;
         cur_chan_ff   <= cur_chan_in;
         err_ff        <= err_in;
         vpend_ff      <= vpend_in;
      end
   end

`ifndef SYNTHESIS
   a_vpend_after_fmt: assert property (@(posedge clock) disable iff (reset)
      vpend_ff |-> fmt_found_ff)
      else $error("format check pending without a format chunk");
   a_right_only_stereo: assert property (@(posedge clock) disable iff (reset)
      cur_chan_ff |-> (chan_word_ff == 16'd2))
      else $error("right channel selected on a non-stereo stream");
   a_mid_sample_bytes: assert property (@(posedge clock) disable iff (reset)
      (bis_ff != 2'd0) |-> (remain_ff != 32'd0))
      else $error("partial sample with no data bytes left");
`endif

endmodule

[rtl/wpu_rsp_fifo.sv]
// wpu_rsp_fifo: small result queue, takes up to two results a cycle
// decouples the parser from back-pressure on the result channel
// depends on wpu_pkg
module wpu_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wpu_pkg::wpu_push_type   push,
   output logic                    space,
   output logic                    out_valid,
   input  logic                    out_ready,
   output wpu_pkg::wpu_result_type out_item
);
   import wpu_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wpu_result_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;
   logic [1:0]       n_push;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      wrap_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   // room for a sample and a status report together
   assign space     = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ff];

   always_comb begin
      pop      = out_valid && out_ready;
      n_push   = {1'b0, push.sample_valid} + {1'b0, push.status_valid};
      wr_next  = wrap_inc(wr_ff);
      wr_in    = wr_ff;
      case (n_push)
         2'd1: wr_in = wr_next;
         2'd2: wr_in = wrap_inc(wr_next);
         default: wr_in = wr_ff;
      endcase
      rd_in    = pop ? wrap_inc(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.sample_valid) begin
         mem[wr_ff] <= push.sample;
         if (push.status_valid) begin
            mem[wr_next] <= push.status;
         end
      end else if (push.status_valid) begin
         mem[wr_ff] <= push.status;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");
`endif

endmodule

[rtl/wav_pcm_stream_unpacker.sv]
// wav_pcm_stream_unpacker: top level of the streaming wav pcm parser
// instantiates wpu_in_reg, wpu_parser and wpu_rsp_fifo; depends on wpu_pkg
//
// The block reads a WAV file one byte per transaction on the req channel (tlast
// marks the last byte of the file) and returns transactions on the rsp channel:
// a decoded sample (tuser 0) for each complete sample of the data chunk, and
// one status report (tuser 1, tlast 1) after the last byte. Samples are signed,
// left-justified to 32 bits; 8-bit samples are offset by 128.
// Only whole frames of the data size are unpacked, and none at all if the
// format is rejected. Throughput is one byte per clock cycle, sustained, as
// long as the rsp side takes its transactions; from byte to sample, a byte is
// held in the input register, then the parse logic writes the result queue.
// The rate is set by the result queue: it accepts a byte only while it has
// room for two results, since the final byte can give a sample and the status.
// After the status report the block is back in its reset state for the next
// file. There is no clearing pass after reset.
module wav_pcm_stream_unpacker #(
   parameter int RSP_DEPTH = 4   // result queue entries, 3 or more
) (
   input  logic         clock,
   input  logic         reset,
   // byte stream in
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] file_byte
   input  logic         req_tlast,   // end_of_file
   // results out
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] channel, [32:1] sample_value, [33] frame_end, [36:34] status,
   // [68:37] sample_rate, [84:69] bits_per_sample, [100:85] channel_count,
   // [103:101] zero
   output logic [103:0] rsp_tdata,
   output logic         rsp_tuser,   // [0] kind: 0 sample, 1 status report
   output logic         rsp_tlast    // last: set on the status report
);
   import wpu_pkg::*;

   wpu_byte_type   req_item;
   wpu_byte_type   byte_item;
   logic           byte_valid;
   logic           byte_take;
   logic           rsp_space;
   wpu_push_type   push;
   wpu_result_type rsp_item;

   assign req_item.file_byte   = req_tdata;
   assign req_item.end_of_file = req_tlast;

   // a held byte is parsed as soon as the result queue has room
   assign byte_take = byte_valid && rsp_space;

   wpu_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (byte_valid),
      .out_take  (byte_take),
      .out_item  (byte_item)
   );

   wpu_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_go   (byte_take),
      .in_item (byte_item),
      .push    (push)
   );

   wpu_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (rsp_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // pack the result record onto the stream, first field lowest
   assign rsp_tdata = {3'b000,
                       rsp_item.channel_count,
                       rsp_item.bits_per_sample,
                       rsp_item.sample_rate,
                       rsp_item.status,
                       rsp_item.frame_end,
                       rsp_item.sample_value,
                       rsp_item.channel};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule
